@@ hdl/lh_pkg.sv @@
// Luma histogram package: widths, reset values, opcodes, register indexes,
// the command and result records, and the back-end state encoding.
// No dependencies.
`default_nettype none

package lh_pkg;

  // Default sizing of the bin store
  localparam int BIN_COUNT_DFLT  = 256;
  localparam int COUNT_BITS_DFLT = 32;

  // Datapath widths
  localparam int WEIGHT_W      = 16;
  localparam int CHAN_W        = 8;
  localparam int PROD_W        = WEIGHT_W + CHAN_W;
  localparam int SUM_W         = PROD_W + 2;
  localparam int LUMA_SHIFT    = 16;
  localparam int LUMA_W        = 8;
  localparam int SEL_W         = 8;
  localparam int BIN_IDX_MAX_W = 12;
  localparam int OUT_COUNT_W   = 32;
  localparam int OPCODE_W      = 2;
  localparam int CFG_IDX_W     = 2;

  localparam logic [LUMA_W-1:0] LUMA_MAX = 8'd255;

  // Queue depths
  localparam int CMD_Q_DEPTH = 4;
  localparam int RES_Q_DEPTH = 2;

  // BT.709 weights, unsigned Q0.16
  localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RST   = 16'd13933;
  localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RST = 16'd46871;
  localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RST  = 16'd4732;

  // Input opcodes
  localparam logic [OPCODE_W-1:0] OP_ADD        = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ       = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_READ,
    CMD_READ_CLEAR
  } cmd_kind_t;

  // Classified work item passed from front end to back end
  typedef struct packed {
    cmd_kind_t                kind;
    logic [BIN_IDX_MAX_W-1:0] bin;
    logic [SEL_W-1:0]         sel;
    logic                     in_range;
  } cmd_t;

  typedef struct packed {
    logic [SEL_W-1:0]       bin_number;
    logic [OUT_COUNT_W-1:0] bin_count;
  } result_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RMW
  } back_state_t;

endpackage

`default_nettype wire

@@ hdl/lh_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/lh_fifo.sv @@
// Small register FIFO with push/full and pop/empty sides.
// No dependencies; DEPTH must be a power of two.
`default_nettype none

module lh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (PTR_W+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and fill-level update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ hdl/lh_front.sv @@
// Luma histogram front end: weight registers, pixel multiply stage, luma
// and bin classification, command push. Depends on lh_pkg.
`default_nettype none

module lh_front #(
  parameter int BIN_COUNT = lh_pkg::BIN_COUNT_DFLT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [lh_pkg::WEIGHT_W-1:0]         cfg_data,
  // input items
  input  wire logic                                in_push,
  output logic                                     in_full,
  input  wire logic [lh_pkg::OPCODE_W-1:0]         in_opcode,
  input  wire logic [lh_pkg::CHAN_W-1:0]           in_red,
  input  wire logic [lh_pkg::CHAN_W-1:0]           in_green,
  input  wire logic [lh_pkg::CHAN_W-1:0]           in_blue,
  input  wire logic [lh_pkg::SEL_W-1:0]            in_bin_select,
  // back end status and command queue
  input  wire logic                                clearing,
  output logic                                     cmd_push,
  output lh_pkg::cmd_t                             cmd_data,
  input  wire logic                                cmd_full
);

  localparam int PW  = lh_pkg::PROD_W;
  localparam int SW  = lh_pkg::SUM_W;
  localparam int LWW = lh_pkg::SUM_W - lh_pkg::LUMA_SHIFT;
  localparam int BIW = lh_pkg::BIN_IDX_MAX_W;

  logic [lh_pkg::WEIGHT_W-1:0] weight_red_r, weight_green_r, weight_blue_r;

  logic                        s1_v_r, s1_v_nxt;
  logic [lh_pkg::OPCODE_W-1:0] s1_op_r;
  logic [lh_pkg::SEL_W-1:0]    s1_sel_r;
  logic [PW-1:0]               s1_pr_r, s1_pg_r, s1_pb_r;

  logic [SW-1:0]               sum;
  logic [LWW-1:0]              luma_wide;
  logic [lh_pkg::LUMA_W-1:0]   luma;
  logic [BIW-1:0]              pix_bin;
  logic                        op_ok;
  logic                        advance;
  logic                        accept;

  // configuration writes, always taken; unknown index ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_red_r   <= lh_pkg::WEIGHT_RED_RST;
      weight_green_r <= lh_pkg::WEIGHT_GREEN_RST;
      weight_blue_r  <= lh_pkg::WEIGHT_BLUE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lh_pkg::REG_WEIGHT_RED:   weight_red_r   <= cfg_data;
        lh_pkg::REG_WEIGHT_GREEN: weight_green_r <= cfg_data;
        lh_pkg::REG_WEIGHT_BLUE:  weight_blue_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // luma from registered products, saturated, then clamped to the last bin
  always_comb begin
    sum       = SW'(s1_pr_r) + SW'(s1_pg_r) + SW'(s1_pb_r);
    luma_wide = sum[SW-1:lh_pkg::LUMA_SHIFT];
    luma      = (luma_wide > LWW'(lh_pkg::LUMA_MAX)) ? lh_pkg::LUMA_MAX
                                                     : luma_wide[lh_pkg::LUMA_W-1:0];
    if (32'(luma) >= 32'(BIN_COUNT)) begin
      pix_bin = BIW'(BIN_COUNT - 1);
    end else begin
      pix_bin = BIW'(luma);
    end
  end

  // classify the item held in stage 1
  always_comb begin
    op_ok             = 1'b1;
    cmd_data.kind     = lh_pkg::CMD_READ;
    cmd_data.bin      = BIW'(s1_sel_r);
    cmd_data.sel      = s1_sel_r;
    cmd_data.in_range = (32'(s1_sel_r) < 32'(BIN_COUNT));
    case (s1_op_r)
      lh_pkg::OP_ADD: begin
        cmd_data.kind     = lh_pkg::CMD_ADD;
        cmd_data.bin      = pix_bin;
        cmd_data.in_range = 1'b1;
      end
      lh_pkg::OP_READ: begin
        cmd_data.kind = lh_pkg::CMD_READ;
      end
      lh_pkg::OP_READ_CLEAR: begin
        cmd_data.kind = lh_pkg::CMD_READ_CLEAR;
      end
      default: begin
        // opcode three is dropped here
        op_ok = 1'b0;
      end
    endcase
  end

  // stage 1 moves when it is empty, drops its item, or the queue has room
  always_comb begin
    cmd_push = s1_v_r && op_ok && !cmd_full;
    advance  = !s1_v_r || !op_ok || !cmd_full;
    in_full  = clearing || !advance;
    accept   = in_push && !in_full;
    s1_v_nxt = advance ? accept : s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // multiply stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r  <= in_opcode;
      s1_sel_r <= in_bin_select;
      s1_pr_r  <= PW'(weight_red_r) * PW'(in_red);
      s1_pg_r  <= PW'(weight_green_r) * PW'(in_green);
      s1_pb_r  <= PW'(weight_blue_r) * PW'(in_blue);
    end
  end

endmodule

`default_nettype wire

@@ hdl/lh_back.sv @@
// Luma histogram back end: clearing pass and read-modify-write of the bin
// memory. Depends on lh_pkg and lh_ram.
`default_nettype none

module lh_back #(
  parameter int BIN_COUNT  = lh_pkg::BIN_COUNT_DFLT,
  parameter int COUNT_BITS = lh_pkg::COUNT_BITS_DFLT
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // command queue
  input  wire logic         cmd_empty,
  output logic              cmd_pop,
  input  wire lh_pkg::cmd_t cmd_data,
  // result queue
  input  wire logic         res_full,
  output logic              res_push,
  output lh_pkg::result_t   res_data,
  // status
  output logic              clearing
);

  localparam int IDX_W = $clog2(BIN_COUNT);
  localparam int OCW   = lh_pkg::OUT_COUNT_W;

  lh_pkg::back_state_t state_r, state_nxt;
  logic [IDX_W-1:0]    clr_addr_r, clr_addr_nxt;
  lh_pkg::cmd_t        cmd_r, cmd_nxt;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [OCW-1:0]        out_cnt;

  lh_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(BIN_COUNT)
  ) u_bins (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // count read back for this command; out-of-range reads see zero
  assign cnt     = cmd_r.in_range ? ram_rdata : '0;
  assign cnt_inc = (&cnt) ? cnt : cnt + 1'b1;

  // result count saturates when the store is wider than the port
  if (COUNT_BITS > OCW) begin : g_out_sat
    assign out_cnt = (|cnt[COUNT_BITS-1:OCW]) ? '1 : cnt[OCW-1:0];
  end else begin : g_out_ext
    assign out_cnt = OCW'(cnt);
  end

  assign ram_raddr           = cmd_data.bin[IDX_W-1:0];
  assign res_data.bin_number = cmd_r.sel;
  assign res_data.bin_count  = out_cnt;
  assign clearing            = (state_r == lh_pkg::BK_CLEAR);

  // sequencer: clear sweep, then fetch / update per command
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cmd_nxt      = cmd_r;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = cmd_r.bin[IDX_W-1:0];
    ram_wdata    = '0;
    case (state_r)
      lh_pkg::BK_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == IDX_W'(BIN_COUNT - 1)) begin
          state_nxt = lh_pkg::BK_IDLE;
        end
      end
      lh_pkg::BK_IDLE: begin
        // one result in flight at most, so room now means room at write back
        if (!cmd_empty && !res_full) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd_data;
          state_nxt = lh_pkg::BK_RMW;
        end
      end
      lh_pkg::BK_RMW: begin
        case (cmd_r.kind)
          lh_pkg::CMD_ADD: begin
            ram_we    = 1'b1;
            ram_wdata = cnt_inc;
          end
          lh_pkg::CMD_READ_CLEAR: begin
            ram_we   = cmd_r.in_range;
            res_push = 1'b1;
          end
          default: begin
            res_push = 1'b1;
          end
        endcase
        state_nxt = lh_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = lh_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lh_pkg::BK_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/luma_histogram.sv @@
// Luma histogram top level: front end, command queue, back end, result queue.
// Depends on lh_pkg, lh_fifo, lh_front, lh_back.
//
// Usage:
//   Input channel (in_push / in_full): add-pixel, read-bin and read-and-clear
//   items. A transfer happens on a clock edge with in_push high and in_full low.
//   Result channel (out_empty / out_pop): one result per read item, oldest
//   first; a transfer happens on an edge with out_pop high and out_empty low.
//   Config channel (cfg_valid / cfg_ready): luma weights, written while idle.
// Datapath:
//   A read item passes the multiply stage register, the command queue, the
//   back end (memory read, then write back) and the result queue. The back
//   end takes no new item until the last one is written back; the
//   command queue absorbs bursts at the input.
// Reset:
//   rst_n restores the default weights and empties both queues, then the
//   bin memory is zeroed in a pass over all bins, during which in_full
//   stays high. Config writes are taken throughout.
// Stalls:
//   While out_pop is low the result queue fills, then the command queue,
//   then in_full rises; nothing is dropped.
`default_nettype none

module luma_histogram #(
  parameter int BIN_COUNT  = lh_pkg::BIN_COUNT_DFLT,
  parameter int COUNT_BITS = lh_pkg::COUNT_BITS_DFLT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lh_pkg::WEIGHT_W-1:0]    cfg_data,
  // input items
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [lh_pkg::OPCODE_W-1:0]    in_opcode,
  input  wire logic [lh_pkg::CHAN_W-1:0]      in_red,
  input  wire logic [lh_pkg::CHAN_W-1:0]      in_green,
  input  wire logic [lh_pkg::CHAN_W-1:0]      in_blue,
  input  wire logic [lh_pkg::SEL_W-1:0]       in_bin_select,
  // results
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic      [lh_pkg::SEL_W-1:0]       out_bin_number,
  output logic      [lh_pkg::OUT_COUNT_W-1:0] out_bin_count
);

  logic            clearing;
  logic            cmd_push, cmd_full, cmd_pop, cmd_empty;
  lh_pkg::cmd_t    cmd_in, cmd_out;
  logic            res_push, res_full;
  lh_pkg::result_t res_in, res_out;

  lh_front #(
    .BIN_COUNT(BIN_COUNT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_opcode    (in_opcode),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_bin_select(in_bin_select),
    .clearing     (clearing),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_in),
    .cmd_full     (cmd_full)
  );

  // command queue between front and back
  lh_fifo #(
    .WIDTH($bits(lh_pkg::cmd_t)),
    .DEPTH(lh_pkg::CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cmd_push),
    .wdata(cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_out),
    .empty(cmd_empty)
  );

  lh_back #(
    .BIN_COUNT (BIN_COUNT),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .cmd_data (cmd_out),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_in),
    .clearing (clearing)
  );

  // result queue toward the consumer
  lh_fifo #(
    .WIDTH($bits(lh_pkg::result_t)),
    .DEPTH(lh_pkg::RES_Q_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (out_pop),
    .rdata(res_out),
    .empty(out_empty)
  );

  assign out_bin_number = res_out.bin_number;
  assign out_bin_count  = res_out.bin_count;

endmodule

`default_nettype wire

@@ hdl/lh_checker.sv @@
// Port-level checks for luma_histogram, attached by bind.
// Depends on luma_histogram's port list.
`default_nettype none

module lh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_push,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [7:0]  out_bin_number,
  input wire logic [31:0] out_bin_count
);

  // the memory clear sweep blocks input right after reset
  a_full_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_full)
    else $error("input not held off after reset");

  // no stale result survives reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result visible right after reset");

  // a result that is not taken stays and holds its value
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=>
      !out_empty && $stable(out_bin_number) && $stable(out_bin_count))
    else $error("pending result changed or vanished");

  // handshake lines carry known levels out of reset
  a_handshake_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_push, in_full, out_pop, out_empty}))
    else $error("unknown level on a handshake line");

  // a pending result carries known data
  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !$isunknown({out_bin_number, out_bin_count}))
    else $error("pending result has unknown bits");

endmodule

bind luma_histogram lh_checker u_lh_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for luma_histogram: drives pixel and bin-read transfers,
// predicts every read result from its own histogram copy and checks them in order.
// Depends on lh_pkg and the luma_histogram RTL.
`timescale 1ns / 100ps

module testbench;
  import lh_pkg::*;

  localparam int BINS          = BIN_COUNT_DFLT;
  localparam int CNT_BITS      = COUNT_BITS_DFLT;
  localparam int SETTLE_CYCLES = 40;    // back end finishing queued pixel adds
  localparam int QUIET_LIMIT   = 2000;  // cycles without any transfer
  localparam int PHASE_ITEMS   = 100;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic [SEL_W-1:0]    bin_select;
  } hist_cmd_t;

  // DUT connections; the driven inputs start at known values
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_WEIGHT_RED;
  logic [WEIGHT_W-1:0]    cfg_data = '0;
  logic                   in_push = 1'b0;
  logic                   in_full;
  logic [OPCODE_W-1:0]    in_opcode = OP_ADD;
  logic [CHAN_W-1:0]      in_red = '0;
  logic [CHAN_W-1:0]      in_green = '0;
  logic [CHAN_W-1:0]      in_blue = '0;
  logic [SEL_W-1:0]       in_bin_select = '0;
  logic                   out_empty;
  logic                   out_pop = 1'b0;
  logic [SEL_W-1:0]       out_bin_number;
  logic [OUT_COUNT_W-1:0] out_bin_count;

  // Predictor state
  logic [CNT_BITS-1:0] bin_tally [BINS];
  logic [WEIGHT_W-1:0] w_red, w_green, w_blue;
  result_t             read_expect [$];

  // Stimulus state
  hist_cmd_t   cmd_backlog [$];
  logic [7:0]  recent_bins [$];
  logic [23:0] palette_rgb [4];
  int          items_queued = 0;
  int          items_taken = 0;
  int          error_count = 0;

  // Driver / monitor / watchdog state
  hist_cmd_t cur_cmd;
  logic      took, push_next, pop_next, calm;
  int        burst_left = 0, gap_left = 0;
  int        stall_left = 0, mode_left = 0;
  int        quiet_cycles = 0;

  always #5 clk = ~clk;

  luma_histogram dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_opcode     (in_opcode),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_bin_select (in_bin_select),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_bin_number(out_bin_number),
    .out_bin_count (out_bin_count)
  );

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Weighted sum, shifted down and clamped to 8 bits
  function automatic logic [7:0] luma_bin(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(w_red) * SUM_W'(r) + SUM_W'(w_green) * SUM_W'(g)
        + SUM_W'(w_blue) * SUM_W'(b);
    if ((sum >> LUMA_SHIFT) > LUMA_MAX) return LUMA_MAX;
    return sum[LUMA_SHIFT +: 8];
  endfunction

  // Apply one accepted item to the histogram copy; reads queue a result
  task automatic histogram_step(input hist_cmd_t c);
    int          bin;
    logic [63:0] cnt;
    result_t     res;
    case (c.opcode)
      OP_ADD: begin
        bin = luma_bin(c.red, c.green, c.blue);
        if (bin >= BINS) bin = BINS - 1;
        if (bin_tally[bin] != {CNT_BITS{1'b1}}) bin_tally[bin] = bin_tally[bin] + 1'b1;
      end
      OP_READ, OP_READ_CLEAR: begin
        cnt = '0;
        if (int'(c.bin_select) < BINS) begin
          cnt = 64'(bin_tally[c.bin_select]);
          if (c.opcode == OP_READ_CLEAR) bin_tally[c.bin_select] = '0;
        end
        if (cnt > 64'hFFFF_FFFF) cnt = 64'hFFFF_FFFF;
        res.bin_number = c.bin_select;
        res.bin_count  = cnt[31:0];
        read_expect.push_back(res);
      end
      default: ;  // unused opcode: no effect
    endcase
  endtask

  // Input driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      took = in_push && !in_full;
      if (took) begin
        histogram_step(cur_cmd);
        items_taken++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left = 64;
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      if (in_push && !took) begin
        push_next = 1'b1;  // hold until transfer
      end else if (gap_left > 0) begin
        gap_left--;
        push_next = 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        cur_cmd   = cmd_backlog.pop_front();
        push_next = 1'b1;
      end else begin
        push_next = 1'b0;
      end
      in_push <= push_next;
      if (push_next) begin
        in_opcode     <= cur_cmd.opcode;
        in_red        <= cur_cmd.red;
        in_green      <= cur_cmd.green;
        in_blue       <= cur_cmd.blue;
        in_bin_select <= cur_cmd.bin_select;
      end else begin
        // noise on the idle bus
        in_opcode     <= OPCODE_W'($urandom);
        in_red        <= CHAN_W'($urandom);
        in_green      <= CHAN_W'($urandom);
        in_blue       <= CHAN_W'($urandom);
        in_bin_select <= SEL_W'($urandom);
      end
    end
  end

  // Result monitor: check each transfer, start stalls only in busy stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (read_expect.size() == 0) begin
          flag_error($sformatf("result bin %0d count %0d with nothing expected",
                               out_bin_number, out_bin_count));
        end else begin
          result_t want;
          want = read_expect.pop_front();
          if (out_bin_number !== want.bin_number)
            flag_error($sformatf("bin_number got %0d want %0d",
                                 out_bin_number, want.bin_number));
          if (out_bin_count !== want.bin_count)
            flag_error($sformatf("bin_count of bin %0d got %0d want %0d",
                                 want.bin_number, out_bin_count, want.bin_count));
        end
      end
      if (mode_left == 0) begin
        calm      = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop_next = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 19);
        pop_next   = 1'b0;
      end else begin
        pop_next = 1'b1;
      end
      out_pop <= pop_next;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_weight(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WEIGHT_RED:   w_red   = val;
      REG_WEIGHT_GREEN: w_green = val;
      REG_WEIGHT_BLUE:  w_blue  = val;
      default: ;
    endcase
  endtask

  task automatic queue_cmd(input logic [OPCODE_W-1:0] op, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b, input logic [7:0] sel);
    hist_cmd_t c;
    c.opcode     = op;
    c.red        = r;
    c.green      = g;
    c.blue       = b;
    c.bin_select = sel;
    cmd_backlog.push_back(c);
    items_queued++;
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly adds; reads favor bins that recent pixels landed in
  task automatic queue_random_item(output bit counted);
    int          roll;
    logic [23:0] rgb;
    logic [7:0]  sel;
    roll    = $urandom_range(0, 99);
    counted = 1'b1;
    if (roll < 58) begin
      if ($urandom_range(0, 1) == 0) rgb = palette_rgb[$urandom_range(0, 3)];
      else rgb = {pick_channel(), pick_channel(), pick_channel()};
      queue_cmd(OP_ADD, rgb[23:16], rgb[15:8], rgb[7:0], 8'($urandom));
      recent_bins.push_back(luma_bin(rgb[23:16], rgb[15:8], rgb[7:0]));
      if (recent_bins.size() > 16) void'(recent_bins.pop_front());
    end else if (roll < 95) begin
      if (recent_bins.size() > 0 && $urandom_range(0, 3) != 0)
        sel = recent_bins[$urandom_range(0, recent_bins.size() - 1)];
      else
        sel = 8'($urandom);
      queue_cmd((roll < 78) ? OP_READ : OP_READ_CLEAR, 8'($urandom), 8'($urandom),
                8'($urandom), sel);
    end else begin
      queue_cmd(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      counted = 1'b0;
    end
  endtask

  // Wait for the driver and the result side to run dry, then let the back end settle
  task automatic settle();
    do @(negedge clk);
    while (items_taken != items_queued || read_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Stimulus: one phase per weight setting
  initial begin
    logic [WEIGHT_W-1:0] phase_w [7][3];
    int  counted_items;
    bit  counted;

    phase_w[0] = '{WEIGHT_RED_RST, WEIGHT_GREEN_RST, WEIGHT_BLUE_RST};
    phase_w[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    phase_w[2] = '{16'h0000, 16'h0000, 16'h0000};
    phase_w[3] = '{16'hFFFF, 16'h0000, 16'h0001};
    phase_w[4] = '{16'($urandom), 16'($urandom), 16'($urandom)};
    phase_w[5] = '{16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                   16'($urandom_range(0, 32767))};
    phase_w[6] = '{WEIGHT_RED_RST, WEIGHT_GREEN_RST, WEIGHT_BLUE_RST};

    foreach (bin_tally[i]) bin_tally[i] = '0;
    w_red   = WEIGHT_RED_RST;
    w_green = WEIGHT_GREEN_RST;
    w_blue  = WEIGHT_BLUE_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 7; p++) begin
      write_weight(REG_WEIGHT_RED,   phase_w[p][0]);
      write_weight(REG_WEIGHT_GREEN, phase_w[p][1]);
      write_weight(REG_WEIGHT_BLUE,  phase_w[p][2]);
      @(negedge clk);
      foreach (palette_rgb[i]) palette_rgb[i] = 24'($urandom);
      recent_bins.delete();

      if (p == 0) begin
        // channel extremes, every opcode, clear then re-read, unused opcode
        queue_cmd(OP_ADD, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_cmd(OP_ADD, 8'd255, 8'd255, 8'd255, 8'd255);
        queue_cmd(OP_ADD, 8'd255, 8'd255, 8'd255, 8'd0);
        queue_cmd(OP_ADD, 8'd255, 8'd0, 8'd0, 8'd0);
        queue_cmd(OP_ADD, 8'd0, 8'd255, 8'd0, 8'd0);
        queue_cmd(OP_ADD, 8'd0, 8'd0, 8'd255, 8'd0);
        queue_cmd(OP_ADD, 8'd128, 8'd128, 8'd128, 8'd0);
        queue_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_cmd(OP_READ, 8'd255, 8'd255, 8'd255, 8'd255);
        queue_cmd(OP_UNUSED, 8'd0, 8'd0, 8'd0, 8'd255);
        queue_cmd(OP_UNUSED, 8'd255, 8'd255, 8'd255, 8'd0);
        queue_cmd(OP_READ_CLEAR, 8'd0, 8'd0, 8'd0, 8'd255);
        queue_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd255);
        queue_cmd(OP_READ_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_cmd(OP_READ_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd127);
        queue_cmd(OP_READ_CLEAR, 8'd0, 8'd0, 8'd0, 8'd128);
        queue_cmd(OP_READ, 8'd255, 8'd0, 8'd0, 8'd54);
      end else if (p == 1) begin
        // weights summing past 1.0: bright pixels saturate into the top bin
        queue_cmd(OP_ADD, 8'd255, 8'd255, 8'd255, 8'd0);
        queue_cmd(OP_ADD, 8'd1, 8'd1, 8'd1, 8'd0);
        queue_cmd(OP_ADD, 8'd86, 8'd85, 8'd85, 8'd0);
        queue_cmd(OP_READ_CLEAR, 8'd0, 8'd0, 8'd0, 8'd255);
        queue_cmd(OP_READ_CLEAR, 8'd0, 8'd0, 8'd0, 8'd2);
      end

      counted_items = 0;
      while (counted_items < PHASE_ITEMS) begin
        queue_random_item(counted);
        if (counted) counted_items++;
      end
      settle();
    end

    if (read_expect.size() != 0)
      flag_error($sformatf("%0d results never arrived", read_expect.size()));
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
